// ----- sv/vfc_pkg.sv -----
// Package for the voxel face cull core: sizes, function and face codes,
// and the cell address and chunk border helpers. No dependencies.
package vfc_pkg;

    localparam int SIDE       = 16;
    localparam int BLOCK_BITS = 8;
    localparam int COORD_W    = 4;
    localparam int CODE_W     = 8;
    localparam int FACE_W     = 3;
    localparam int NUM_FACES  = 6;
    localparam int CELLS      = SIDE * SIDE * SIDE;
    localparam int ADDR_W     = $clog2(CELLS);

    typedef logic [COORD_W-1:0]    coord_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [BLOCK_BITS-1:0] block_t;
    typedef logic [FACE_W-1:0]     face_t;
    typedef logic [NUM_FACES-1:0]  face_mask_t;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_MESH  = 1'b1;

    localparam face_t FACE_DOWN  = 3'd0;
    localparam face_t FACE_UP    = 3'd1;
    localparam face_t FACE_LEFT  = 3'd2;
    localparam face_t FACE_RIGHT = 3'd3;
    localparam face_t FACE_FRONT = 3'd4;
    localparam face_t FACE_BACK  = 3'd5;

    localparam coord_t COORD_MAX = COORD_W'(SIDE - 1);

    function automatic logic in_chunk(coord_t x, coord_t y, coord_t z);
        in_chunk = (int'(x) < SIDE) && (int'(y) < SIDE) && (int'(z) < SIDE);
    endfunction

    function automatic addr_t cell_addr(coord_t x, coord_t y, coord_t z);
        cell_addr = (ADDR_W'(x) * ADDR_W'(SIDE) + ADDR_W'(y)) * ADDR_W'(SIDE)
                    + ADDR_W'(z);
    endfunction

    // Neighbor beyond the chunk edge on the given face
    function automatic logic at_border(coord_t x, coord_t y, coord_t z, face_t f);
        case (f)
            FACE_DOWN:  at_border = (y == '0);
            FACE_UP:    at_border = (y == COORD_MAX);
            FACE_LEFT:  at_border = (x == '0);
            FACE_RIGHT: at_border = (x == COORD_MAX);
            FACE_FRONT: at_border = (z == '0);
            FACE_BACK:  at_border = (z == COORD_MAX);
            default:    at_border = 1'b1;
        endcase
    endfunction

    // Neighbor address; the caller falls back to the center on a border face
    function automatic addr_t nb_addr(coord_t x, coord_t y, coord_t z, face_t f);
        case (f)
            FACE_DOWN:  nb_addr = cell_addr(x, y - COORD_W'(1), z);
            FACE_UP:    nb_addr = cell_addr(x, y + COORD_W'(1), z);
            FACE_LEFT:  nb_addr = cell_addr(x - COORD_W'(1), y, z);
            FACE_RIGHT: nb_addr = cell_addr(x + COORD_W'(1), y, z);
            FACE_FRONT: nb_addr = cell_addr(x, y, z - COORD_W'(1));
            FACE_BACK:  nb_addr = cell_addr(x, y, z + COORD_W'(1));
            default:    nb_addr = cell_addr(x, y, z);
        endcase
    endfunction

endpackage

// ----- sv/voxel_face_cull_core.sv -----
// Voxel face cull core: block code store in one synchronous memory and a
// sequencer that scans the six neighbors of a meshed cell.
// Depends on vfc_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one word per item: func,
//   cell_x, cell_y, cell_z, block_code. A write word (func 0) stores the low
//   BLOCK_BITS bits of block_code at the cell in the accept cycle and gives
//   no output. A mesh word (func 1) reads the cell; an air cell gives no
//   output, a solid cell emits one record per visible face on the output
//   channel (out_valid/out_stall), order down, up, left, right, front, back,
//   with last_face set on the final record.
//   Timing: a write word does not stall the input. A mesh item holds in_stall
//   high through the center check (S_CHECK) on an air cell. On a solid cell
//   in_stall stays high through the center check, the six neighbor reads
//   (S_SCAN) through the single memory read port and the six emit slots
//   (S_EMIT), longer while the receiver stalls. The first record is loaded
//   into the output register from S_EMIT, after S_CHECK and S_SCAN.
//   An output register holds the current record while out_stall is high;
//   the sequencer waits and the input stays stalled until all records are loaded into the output register.
//   Reset clears the sequencer and the output valid; the store is not
//   cleared and must be written before it is meshed.
module voxel_face_cull_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 func,
    input  vfc_pkg::coord_t      cell_x,
    input  vfc_pkg::coord_t      cell_y,
    input  vfc_pkg::coord_t      cell_z,
    input  logic [vfc_pkg::CODE_W-1:0] block_code,
    output logic                 out_valid,
    input  logic                 out_stall,
    output vfc_pkg::coord_t      out_x,
    output vfc_pkg::coord_t      out_y,
    output vfc_pkg::coord_t      out_z,
    output vfc_pkg::face_t       face_code,
    output logic                 last_face
);
    import vfc_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    block_t mem [CELLS];
    block_t rd_data_reg;

    logic [1:0] state_reg, state_next;
    coord_t     x_reg, y_reg, z_reg;
    face_t      face_reg, face_next;
    logic       border_reg, border_next;
    face_mask_t mask_reg, mask_next;

    logic       out_valid_reg, out_valid_next;
    coord_t     out_x_reg, out_y_reg, out_z_reg;
    face_t      face_code_reg;
    logic       last_face_reg;
    logic       out_load;
    logic       more_faces;

    logic       in_accept;
    logic       wr_en;
    logic       center_ok;
    addr_t      in_addr;
    addr_t      rd_addr;
    face_t      face_inc;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign in_addr   = cell_addr(cell_x, cell_y, cell_z);
    assign center_ok = in_chunk(cell_x, cell_y, cell_z);
    assign wr_en     = in_accept && (func == FUNC_WRITE) && center_ok;
    assign face_inc  = face_reg + FACE_W'(1);

    always_comb
    begin
        more_faces = 1'b0;
        for (int i = 0; i < NUM_FACES; i++)
        begin
            if ((FACE_W'(i) > face_reg) && mask_reg[i])
            begin
                more_faces = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        face_next      = face_reg;
        border_next    = border_reg;
        mask_next      = mask_reg;
        rd_addr        = in_addr;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (func == FUNC_MESH) && center_ok)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // issue the first neighbor read
                face_next   = FACE_DOWN;
                border_next = at_border(x_reg, y_reg, z_reg, FACE_DOWN);
                mask_next   = '0;
                rd_addr     = border_next ? cell_addr(x_reg, y_reg, z_reg)
                                          : nb_addr(x_reg, y_reg, z_reg, FACE_DOWN);
                state_next  = (rd_data_reg == '0) ? S_IDLE : S_SCAN;
            end
            S_SCAN:
            begin
                mask_next[face_reg] = border_reg || (rd_data_reg == '0);
                if (face_reg == FACE_BACK)
                begin
                    face_next  = FACE_DOWN;
                    state_next = S_EMIT;
                end
                else
                begin
                    face_next   = face_inc;
                    border_next = at_border(x_reg, y_reg, z_reg, face_inc);
                    rd_addr     = border_next ? cell_addr(x_reg, y_reg, z_reg)
                                              : nb_addr(x_reg, y_reg, z_reg, face_inc);
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    if (mask_reg[face_reg])
                    begin
                        out_load       = 1'b1;
                        out_valid_next = 1'b1;
                    end
                    if (face_reg == FACE_BACK)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        face_next = face_inc;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[in_addr] <= block_code[BLOCK_BITS-1:0];
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            x_reg <= cell_x;
            y_reg <= cell_y;
            z_reg <= cell_z;
        end
        face_reg   <= face_next;
        border_reg <= border_next;
        mask_reg   <= mask_next;
        if (out_load)
        begin
            out_x_reg     <= x_reg;
            out_y_reg     <= y_reg;
            out_z_reg     <= z_reg;
            face_code_reg <= face_reg;
            last_face_reg <= !more_faces;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign face_code = face_code_reg;
    assign last_face = last_face_reg;

    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == S_EMIT)
        else $error("output word raised outside emit");

    a_accept_goes_check: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_IDLE || state_reg == S_CHECK)
        else $error("accepted word did not start at center read");

    a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> $past(state_reg) == S_CHECK || $past(state_reg) == S_SCAN)
        else $error("neighbor scan entered without center check");

    a_more_after_nonlast: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_face |-> state_reg == S_EMIT)
        else $error("run ended without last mark");

endmodule

// ----- sim/tb_top.sv -----
// Testbench for voxel_face_cull_core: drives write and mesh words, predicts the
// face words in a scoreboard class and checks each one on acceptance.
// Depends on vfc_pkg and voxel_face_cull_core.
module tb_top;
    import vfc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASE_WORDS = 42;

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
        face_t  face;
        logic   is_last;
    } face_rec_t;

    class face_scoreboard;
        face_rec_t           pending_faces[$];
        bit [BLOCK_BITS-1:0] chunk[CELLS];
        int                  errors;

        function new();
            errors = 0;
            foreach (chunk[i]) chunk[i] = '0;
        endfunction

        function int cell_idx(int x, int y, int z);
            return (x * SIDE + y) * SIDE + z;
        endfunction

        function bit face_open(coord_t x, coord_t y, coord_t z, face_t f);
            int nx;
            int ny;
            int nz;
            nx = int'(x);
            ny = int'(y);
            nz = int'(z);
            case (f)
                FACE_DOWN:  ny = ny - 1;
                FACE_UP:    ny = ny + 1;
                FACE_LEFT:  nx = nx - 1;
                FACE_RIGHT: nx = nx + 1;
                FACE_FRONT: nz = nz - 1;
                default:    nz = nz + 1;
            endcase
            if (nx < 0 || ny < 0 || nz < 0 || nx >= SIDE || ny >= SIDE || nz >= SIDE)
                return 1'b1;
            return chunk[cell_idx(nx, ny, nz)] == '0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task note_word(logic f, coord_t x, coord_t y, coord_t z,
                       logic [CODE_W-1:0] code);
            face_rec_t rec;
            int        last_k;
            if (int'(x) >= SIDE || int'(y) >= SIDE || int'(z) >= SIDE)
                return;
            if (f == FUNC_WRITE)
            begin
                chunk[cell_idx(int'(x), int'(y), int'(z))] = code[BLOCK_BITS-1:0];
                return;
            end
            if (chunk[cell_idx(int'(x), int'(y), int'(z))] == '0)
                return;
            last_k = -1;
            for (int k = 0; k < NUM_FACES; k++)
                if (face_open(x, y, z, face_t'(k)))
                    last_k = k;
            for (int k = 0; k < NUM_FACES; k++)
            begin
                if (face_open(x, y, z, face_t'(k)))
                begin
                    rec.x       = x;
                    rec.y       = y;
                    rec.z       = z;
                    rec.face    = face_t'(k);
                    rec.is_last = (k == last_k);
                    pending_faces.push_back(rec);
                end
            end
        endtask

        task check_face(coord_t x, coord_t y, coord_t z, face_t f, logic is_last);
            face_rec_t want;
            if (pending_faces.size() == 0)
            begin
                report($sformatf("face word (%0d,%0d,%0d) face %0d with none pending",
                                 x, y, z, f));
                return;
            end
            want = pending_faces.pop_front();
            if (x != want.x)
                report($sformatf("out_x got %0d want %0d", x, want.x));
            if (y != want.y)
                report($sformatf("out_y got %0d want %0d", y, want.y));
            if (z != want.z)
                report($sformatf("out_z got %0d want %0d", z, want.z));
            if (f != want.face)
                report($sformatf("face_code got %0d want %0d", f, want.face));
            if (is_last !== want.is_last)
                report($sformatf("last_face got %0d want %0d", is_last, want.is_last));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic              func;
    coord_t            cell_x;
    coord_t            cell_y;
    coord_t            cell_z;
    logic [CODE_W-1:0] block_code;
    logic              out_valid;
    logic              out_stall;
    coord_t            out_x;
    coord_t            out_y;
    coord_t            out_z;
    face_t             face_code;
    logic              last_face;

    face_scoreboard sb;
    bit             written[CELLS];
    int             send_idle;
    int             recv_idle;
    int             hold_reqs;
    int             words_sent;
    int             cycle_count;
    int             nb_dx[NUM_FACES] = '{0, 0, -1, 1, 0, 0};
    int             nb_dy[NUM_FACES] = '{-1, 1, 0, 0, 0, 0};
    int             nb_dz[NUM_FACES] = '{0, 0, 0, 0, -1, 1};

    voxel_face_cull_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .cell_z     (cell_z),
        .block_code (block_code),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_z      (out_z),
        .face_code  (face_code),
        .last_face  (last_face)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL voxel_face_cull_core");
        $finish;
    end

    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_face(out_x, out_y, out_z, face_code, last_face);
    end

    function automatic int idx_of(int x, int y, int z);
        return (x * SIDE + y) * SIDE + z;
    endfunction

    function automatic bit inside_chunk(int x, int y, int z);
        return x >= 0 && y >= 0 && z >= 0 && x < SIDE && y < SIDE && z < SIDE;
    endfunction

    function automatic logic [CODE_W-1:0] rand_code();
        if ($urandom_range(99) < 40)
            return '0;
        return CODE_W'($urandom_range(1, (1 << CODE_W) - 1));
    endfunction

    function automatic int pick_coord();
        int edges[4] = '{0, 1, SIDE - 2, SIDE - 1};
        if ($urandom_range(99) < 40)
            return edges[$urandom_range(3)];
        return $urandom_range(SIDE - 1);
    endfunction

    task automatic send_word(logic f, int x, int y, int z, logic [CODE_W-1:0] code);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        cell_x     <= coord_t'(x);
        cell_y     <= coord_t'(y);
        cell_z     <= coord_t'(z);
        block_code <= code;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_word(func, cell_x, cell_y, cell_z, block_code);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic write_cell(int x, int y, int z, logic [CODE_W-1:0] code);
        written[idx_of(x, y, z)] = 1'b1;
        send_word(FUNC_WRITE, x, y, z, code);
    endtask

    task automatic mesh_cell(int x, int y, int z);
        send_word(FUNC_MESH, x, y, z, CODE_W'($urandom));
    endtask

    function automatic bit cell_ready(int x, int y, int z);
        if (!written[idx_of(x, y, z)])
            return 1'b0;
        for (int k = 0; k < NUM_FACES; k++)
            if (inside_chunk(x + nb_dx[k], y + nb_dy[k], z + nb_dz[k]) &&
                !written[idx_of(x + nb_dx[k], y + nb_dy[k], z + nb_dz[k])])
                return 1'b0;
        return 1'b1;
    endfunction

    // Fill the neighborhood so the mesh never reads an unwritten cell.
    task automatic mesh_sequence(int x, int y, int z);
        int nx;
        int ny;
        int nz;
        if (!written[idx_of(x, y, z)] || $urandom_range(99) < 70)
            write_cell(x, y, z, ($urandom_range(99) < 85) ?
                       CODE_W'($urandom_range(1, (1 << CODE_W) - 1)) : CODE_W'(0));
        for (int k = 0; k < NUM_FACES; k++)
        begin
            nx = x + nb_dx[k];
            ny = y + nb_dy[k];
            nz = z + nb_dz[k];
            if (inside_chunk(nx, ny, nz) &&
                (!written[idx_of(nx, ny, nz)] || $urandom_range(99) < 30))
                write_cell(nx, ny, nz, rand_code());
        end
        mesh_cell(x, y, z);
    endtask

    task automatic random_phase(int goal);
        int x;
        int y;
        int z;
        while (words_sent < goal)
        begin
            x = pick_coord();
            y = pick_coord();
            z = pick_coord();
            if ($urandom_range(99) < 75)
                mesh_sequence(x, y, z);
            else if ($urandom_range(1) == 0 && cell_ready(x, y, z))
                mesh_cell(x, y, z);
            else
                write_cell(x, y, z, CODE_W'($urandom));
        end
    endtask

    initial
    begin
        sb          = new();
        send_idle   = 0;
        recv_idle   = 0;
        hold_reqs   = 0;
        words_sent  = 0;
        cycle_count = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        func        = FUNC_WRITE;
        cell_x      = '0;
        cell_y      = '0;
        cell_z      = '0;
        block_code  = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // lone solid corner: all six faces
        write_cell(0, 0, 0, 8'hFF);
        write_cell(1, 0, 0, 8'h00);
        write_cell(0, 1, 0, 8'h00);
        write_cell(0, 0, 1, 8'h00);
        mesh_cell(0, 0, 0);
        // far corner with solid inner neighbors: border faces only
        write_cell(SIDE - 1, SIDE - 1, SIDE - 1, 8'h01);
        write_cell(SIDE - 2, SIDE - 1, SIDE - 1, 8'h80);
        write_cell(SIDE - 1, SIDE - 2, SIDE - 1, 8'h7F);
        write_cell(SIDE - 1, SIDE - 1, SIDE - 2, 8'hAA);
        mesh_cell(SIDE - 1, SIDE - 1, SIDE - 1);
        // air cell: no faces
        write_cell(2, 0, 0, 8'h55);
        write_cell(1, 1, 0, 8'h00);
        write_cell(1, 0, 1, 8'h00);
        mesh_cell(1, 0, 0);
        // fully enclosed solid cell: no faces
        write_cell(5, 5, 5, 8'h3C);
        for (int k = 0; k < NUM_FACES; k++)
            write_cell(5 + nb_dx[k], 5 + nb_dy[k], 5 + nb_dz[k], CODE_W'(k + 1));
        mesh_cell(5, 5, 5);

        send_idle = 17;
        recv_idle <= 60;
        hold_reqs <= hold_reqs + 1;
        random_phase(words_sent + PHASE_WORDS);
        send_idle = 60;
        recv_idle <= 17;
        random_phase(words_sent + PHASE_WORDS);
        send_idle = 0;
        recv_idle <= 0;
        hold_reqs <= hold_reqs + 1;
        random_phase(words_sent + PHASE_WORDS);

        in_valid <= 1'b0;
        while (sb.pending_faces.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS voxel_face_cull_core");
        else
            $display("FAIL voxel_face_cull_core");
        $finish;
    end
endmodule
